### rtl/msmc_pkg.sv
// Shared types, constants and codes for the MESI snooping multicore cache.
package msmc_pkg;

  localparam int CORES_DEF        = 4;
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  localparam int CORE_FW    = 2;
  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 30;
  localparam int REC_W      = 3;
  localparam int CNT_OUT_W  = 2;
  localparam int CYC_W      = 9;
  localparam int BYTES_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam int MISS_CYC   = 100;
  localparam int WORD_BYTES = 4;
  localparam int BYTES_MAX  = 2047;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef enum logic [1:0] {ST_I, ST_S, ST_E, ST_M} mesi_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    mesi_t            st;
    logic             dirty;
    logic [REC_W-1:0] rec;
  } way_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_OWN, S_LOOKUP, S_PEER_RD, S_PEER_MOD, S_FILL, S_RESULT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd_own;
    logic lookup;
    logic peer_clr;
    logic peer_next;
    logic rd_peer;
    logic snp_mod;
    logic fill;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic snoop_req;
    logic peer_skip;
    logic peer_last;
  } dp_stat_t;

endpackage

### rtl/msmc_in_if.sv
// Request channel: one core access word per handshake.
interface msmc_in_if import msmc_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [CORE_FW-1:0] core;
  logic              action;
  logic [ADDR_W-1:0] address;

  modport source(output valid, core, action, address, input ready);
  modport sink(input valid, core, action, address, output ready);
endinterface

### rtl/msmc_out_if.sv
// Result channel: one access outcome word per handshake.
interface msmc_out_if import msmc_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [1:0]           new_state;
  logic                 evicted;
  logic                 own_writeback;
  logic                 bus_used;
  logic                 supplied_by_peer;
  logic [CNT_OUT_W-1:0] peer_invalidations;
  logic [CNT_OUT_W-1:0] peer_writebacks;
  logic [CYC_W-1:0]     cycles_charged;
  logic [BYTES_W-1:0]   bus_bytes;

  modport source(output valid, hit, new_state, evicted, own_writeback, bus_used,
                 supplied_by_peer, peer_invalidations, peer_writebacks,
                 cycles_charged, bus_bytes, input ready);
  modport sink(input valid, hit, new_state, evicted, own_writeback, bus_used,
               supplied_by_peer, peer_invalidations, peer_writebacks,
               cycles_charged, bus_bytes, output ready);
endinterface

### rtl/msmc_ctrl.sv
// Access sequencer state machine for the snooping cache.
module msmc_ctrl import msmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_RD_OWN;
      S_RD_OWN:   state_nxt = stat.in_range ? S_LOOKUP : S_FILL;
      S_LOOKUP:   state_nxt = stat.snoop_req ? S_PEER_RD : S_FILL;
      S_PEER_RD: begin
        if (!stat.peer_skip) state_nxt = S_PEER_MOD;
        else if (stat.peer_last) state_nxt = S_FILL;
      end
      S_PEER_MOD: state_nxt = stat.peer_last ? S_FILL : S_PEER_RD;
      S_FILL:     state_nxt = S_RESULT;
      S_RESULT:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_RD_OWN:   cmd.rd_own = stat.in_range;
      S_LOOKUP: begin
        cmd.lookup   = 1'b1;
        cmd.peer_clr = 1'b1;
      end
      S_PEER_RD: begin
        cmd.rd_peer   = !stat.peer_skip;
        cmd.peer_next = stat.peer_skip && !stat.peer_last;
      end
      S_PEER_MOD: begin
        cmd.snp_mod   = 1'b1;
        cmd.peer_next = !stat.peer_last;
      end
      S_FILL:     cmd.fill = 1'b1;
      S_RESULT:   cmd.emit = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while an access is in progress");

  a_peer_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEER_MOD) |-> ($past(state_r) == S_PEER_RD))
    else $error("peer update without a preceding peer read");

endmodule

### rtl/msmc_dp.sv
// Datapath: configuration, line memory, lookup, snoop update, fill and result.
module msmc_dp import msmc_pkg::*; #(
  parameter int CORES        = CORES_DEF,
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [CORE_FW-1:0]    in_core,
  input  logic                  in_action,
  input  logic [ADDR_W-1:0]     in_address,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_hit,
  output logic [1:0]            out_new_state,
  output logic                  out_evicted,
  output logic                  out_own_writeback,
  output logic                  out_bus_used,
  output logic                  out_supplied_by_peer,
  output logic [CNT_OUT_W-1:0]  out_peer_invalidations,
  output logic [CNT_OUT_W-1:0]  out_peer_writebacks,
  output logic [CYC_W-1:0]      out_cycles_charged,
  output logic [BYTES_W-1:0]    out_bus_bytes
);

  localparam int CORE_W = $clog2(CORES);
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int ROW_W  = CORE_W + SET_W;
  localparam int ROWS   = 1 << ROW_W;
  localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W  = $clog2(CORES * MAX_WAYS + 1);
  localparam int SUM_W  = 18;

  typedef way_t [MAX_WAYS-1:0] row_t;

  // Configuration registers.
  logic [2:0] sib_r;
  logic [3:0] wiu_r, bbits_r;
  logic [3:0] sb_eff, bb_eff;
  logic [4:0] ways_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sib_r   <= 3'd6;
      wiu_r   <= 4'd8;
      bbits_r <= 4'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   sib_r   <= cfg_wdata[2:0];
        CFG_WAYS:       wiu_r   <= cfg_wdata;
        CFG_BLOCK_BITS: bbits_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sb_eff = (4'(sib_r) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(sib_r);
    if (bbits_r < 4'd2) bb_eff = 4'd2;
    else if (bbits_r > 4'd8) bb_eff = 4'd8;
    else bb_eff = bbits_r;
    if (wiu_r == 4'd0) ways_eff = 5'd1;
    else if (5'(wiu_r) > 5'(MAX_WAYS)) ways_eff = 5'(MAX_WAYS);
    else ways_eff = 5'(wiu_r);
  end

  // Captured request and address decode.
  logic [CORE_FW-1:0] core_r;
  logic               wr_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [ADDR_W-1:0]  set_sh, tag_sh;
  logic [SET_W-1:0]   set_idx;
  logic [TAG_W-1:0]   tag;
  logic               in_range;
  logic [CORE_W-1:0]  peer_r;
  logic [ROW_W-1:0]   own_addr, peer_addr;

  always_comb begin
    set_sh   = (addr_r >> bb_eff) & ~({ADDR_W{1'b1}} << sb_eff);
    set_idx  = SET_W'(set_sh);
    tag_sh   = addr_r >> (5'(sb_eff) + 5'(bb_eff));
    tag      = tag_sh[TAG_W-1:0];
    in_range = 4'(core_r) < 4'(CORES);
    own_addr  = {CORE_W'(core_r), set_idx};
    peer_addr = {peer_r, set_idx};
  end

  // Line memory, one row per core and set; rows never written read as all invalid.
  row_t             mem [ROWS];
  logic [ROWS-1:0]  row_vld_r;
  row_t             rdata_r;
  logic             rvld_r;
  logic             rd_en, we;
  logic [ROW_W-1:0] raddr, waddr;
  row_t             wdata, own_new, peer_new, rv;

  always_comb begin
    rd_en = cmd.rd_own | cmd.rd_peer;
    raddr = cmd.rd_own ? own_addr : peer_addr;
    we    = cmd.snp_mod | (cmd.fill & in_range);
    waddr = cmd.snp_mod ? peer_addr : own_addr;
    wdata = cmd.snp_mod ? peer_new : own_new;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[raddr];
      rvld_r  <= row_vld_r[raddr];
    end
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_vld_r <= '0;
    else if (we) row_vld_r[waddr] <= 1'b1;
  end

  always_comb begin
    rv = rdata_r;
    if (!rvld_r) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        rv[w].st    = ST_I;
        rv[w].dirty = 1'b0;
        rv[w].rec   = '0;
      end
    end
  end

  // Own lookup.
  logic [MAX_WAYS-1:0] act;
  logic                found_any, free_any;
  logic [WIDX_W-1:0]   found_w, free_w, lru_w;

  always_comb begin
    found_any = 1'b0;
    free_any  = 1'b0;
    found_w   = '0;
    free_w    = '0;
    lru_w     = '0;
    for (int w = 0; w < MAX_WAYS; w++) act[w] = 5'(w) < ways_eff;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (act[w] && rv[w].st != ST_I && rv[w].tag == tag) begin
        found_any = 1'b1;
        found_w   = WIDX_W'(w);
      end
      if (act[w] && rv[w].st == ST_I) begin
        free_any = 1'b1;
        free_w   = WIDX_W'(w);
      end
    end
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (act[w] && rv[w].rec > rv[lru_w].rec) lru_w = WIDX_W'(w);
    end
    stat.in_range  = in_range;
    stat.snoop_req = !found_any || (wr_r && rv[found_w].st == ST_S);
    stat.peer_skip = peer_r == CORE_W'(core_r);
    stat.peer_last = peer_r == CORE_W'(CORES - 1);
  end

  logic              hit_r, evict_r, owb_r, snp_r;
  logic [WIDX_W-1:0] way_r;
  mesi_t             hit_st_r;
  row_t              own_row_r;

  // Peer snoop on the row just read.
  logic [MAX_WAYS-1:0] invm, wbm;
  logic                p_shared, p_supp;
  logic                shared_r, supp_r;
  logic [CNT_W-1:0]    inv_r, wb_r;

  always_comb begin
    peer_new = rv;
    invm     = '0;
    wbm      = '0;
    p_shared = 1'b0;
    p_supp   = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (act[w] && rv[w].st != ST_I && rv[w].tag == tag) begin
        if (wr_r) begin
          wbm[w]            = rv[w].st == ST_M;
          invm[w]           = 1'b1;
          peer_new[w].st    = ST_I;
          peer_new[w].dirty = 1'b0;
        end else begin
          p_shared = 1'b1;
          if (rv[w].st == ST_M || rv[w].st == ST_E) begin
            p_supp         = 1'b1;
            wbm[w]         = rv[w].st == ST_M;
            peer_new[w].st = ST_S;
          end
        end
      end
    end
  end

  // Fill / update of the own row, with the recency reranking.
  logic [4:0] cnt;
  always_comb begin
    own_new = own_row_r;
    for (int v = 0; v < MAX_WAYS; v++) begin
      cnt = 5'd1;
      for (int u = 0; u < MAX_WAYS; u++) begin
        if (act[u] && u != v && WIDX_W'(u) != way_r && own_row_r[u].st != ST_I &&
            (own_row_r[u].rec < own_row_r[v].rec ||
             (own_row_r[u].rec == own_row_r[v].rec && u > v)))
          cnt = cnt + 5'd1;
      end
      if (act[v]) begin
        if (WIDX_W'(v) == way_r) own_new[v].rec = '0;
        else if (own_row_r[v].st != ST_I) own_new[v].rec = cnt[REC_W-1:0];
      end
    end
    if (hit_r) begin
      if (wr_r) begin
        own_new[way_r].st    = ST_M;
        own_new[way_r].dirty = 1'b1;
      end
    end else begin
      own_new[way_r].tag   = tag;
      own_new[way_r].st    = wr_r ? ST_M : (shared_r ? ST_S : ST_E);
      own_new[way_r].dirty = wr_r;
    end
  end

  // Result computation.
  logic [8:0]       bsize;
  logic [CYC_W-1:0] cyc;
  logic [SUM_W-1:0] bsum;
  mesi_t            nstate;

  always_comb begin
    bsize = 9'd1 << bb_eff;
    cyc   = 9'd1 + (hit_r ? 9'd0 : 9'(MISS_CYC)) + (owb_r ? 9'(MISS_CYC) : 9'd0)
          + (supp_r ? 9'(bsize >> 1) : 9'd0);
    bsum  = (owb_r ? SUM_W'(bsize) : '0) + (SUM_W'(wb_r) << bb_eff)
          + (hit_r ? '0 : SUM_W'(bsize)) + ((snp_r && wr_r) ? SUM_W'(WORD_BYTES) : '0);
    if (hit_r) nstate = wr_r ? ST_M : hit_st_r;
    else nstate = wr_r ? ST_M : (shared_r ? ST_S : ST_E);
  end

  logic                 res_hit_r, res_evict_r, res_owb_r, res_bus_r, res_supp_r;
  logic [1:0]           res_state_r;
  logic [CNT_OUT_W-1:0] res_inv_r, res_wb_r;
  logic [CYC_W-1:0]     res_cyc_r;
  logic [BYTES_W-1:0]   res_bytes_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      core_r   <= in_core;
      wr_r     <= in_action;
      addr_r   <= in_address;
      shared_r <= 1'b0;
      supp_r   <= 1'b0;
      inv_r    <= '0;
      wb_r     <= '0;
    end
    if (cmd.lookup) begin
      hit_r     <= found_any;
      way_r     <= found_any ? found_w : (free_any ? free_w : lru_w);
      evict_r   <= !found_any && !free_any;
      owb_r     <= !found_any && !free_any && rv[lru_w].dirty;
      snp_r     <= stat.snoop_req;
      hit_st_r  <= rv[found_w].st;
      own_row_r <= rv;
    end
    if (cmd.peer_clr) peer_r <= '0;
    else if (cmd.peer_next) peer_r <= peer_r + CORE_W'(1);
    if (cmd.snp_mod) begin
      shared_r <= shared_r | p_shared;
      supp_r   <= supp_r | p_supp;
      inv_r    <= inv_r + CNT_W'($countones(invm));
      wb_r     <= wb_r + CNT_W'($countones(wbm));
    end
    if (cmd.fill) begin
      if (in_range) begin
        res_hit_r   <= hit_r;
        res_state_r <= nstate;
        res_evict_r <= evict_r;
        res_owb_r   <= owb_r;
        res_bus_r   <= snp_r;
        res_supp_r  <= supp_r;
        res_inv_r   <= (inv_r > CNT_W'(3)) ? 2'd3 : inv_r[1:0];
        res_wb_r    <= (wb_r > CNT_W'(3)) ? 2'd3 : wb_r[1:0];
        res_cyc_r   <= cyc;
        res_bytes_r <= (bsum > SUM_W'(BYTES_MAX)) ? BYTES_W'(BYTES_MAX) : bsum[BYTES_W-1:0];
      end else begin
        res_hit_r   <= 1'b0;
        res_state_r <= ST_I;
        res_evict_r <= 1'b0;
        res_owb_r   <= 1'b0;
        res_bus_r   <= 1'b0;
        res_supp_r  <= 1'b0;
        res_inv_r   <= '0;
        res_wb_r    <= '0;
        res_cyc_r   <= 9'd1;
        res_bytes_r <= '0;
      end
    end
    if (cmd.emit) begin
      out_hit                <= res_hit_r;
      out_new_state          <= res_state_r;
      out_evicted            <= res_evict_r;
      out_own_writeback      <= res_owb_r;
      out_bus_used           <= res_bus_r;
      out_supplied_by_peer   <= res_supp_r;
      out_peer_invalidations <= res_inv_r;
      out_peer_writebacks    <= res_wb_r;
      out_cycles_charged     <= res_cyc_r;
      out_bus_bytes          <= res_bytes_r;
    end
  end

endmodule

### rtl/mesi_snooping_multicore_cache_top.sv
// Top level of the MESI snooping multicore cache model.
// This block models CORES private set-associative write-back caches kept
// coherent by MESI snooping, with LRU replacement. Each request word names a
// core, a read or write, and a byte address; each result word reports the hit,
// the new line state, eviction and writeback events, peer supply and
// invalidation counts, the charged cycles and the bus bytes. All line state
// lives in one row memory with one row per core and set, holding every way,
// read and written through a single port with registered read data. Without a
// bus broadcast (read hit, or write hit to E or M) an access reads its own row,
// looks it up, fills the row and then presents its result word on the output.
// When the access is broadcast, every peer row is read and written back in
// turn through that one memory port between the lookup and the fill, with a
// step past the requester's own row. The sequencer takes the next word only
// once the access is through, and a result waits while the output register
// still holds an unaccepted one. The next word is taken while a finished
// result still waits in the output register. No clearing pass is needed after
// reset: per-row valid flags make untouched rows read as invalid.
// Configuration words may be written only while no access is in progress.
module mesi_snooping_multicore_cache_top import msmc_pkg::*; #(
  parameter int CORES        = CORES_DEF,
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  msmc_in_if.sink               in_ch,
  msmc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Command and status between the sequencer and the datapath.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  msmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  msmc_dp #(
    .CORES        (CORES),
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_core                (in_ch.core),
    .in_action              (in_ch.action),
    .in_address             (in_ch.address),
    .cmd                    (cmd),
    .stat                   (stat),
    .out_hit                (out_ch.hit),
    .out_new_state          (out_ch.new_state),
    .out_evicted            (out_ch.evicted),
    .out_own_writeback      (out_ch.own_writeback),
    .out_bus_used           (out_ch.bus_used),
    .out_supplied_by_peer   (out_ch.supplied_by_peer),
    .out_peer_invalidations (out_ch.peer_invalidations),
    .out_peer_writebacks    (out_ch.peer_writebacks),
    .out_cycles_charged     (out_ch.cycles_charged),
    .out_bus_bytes          (out_ch.bus_bytes)
  );

endmodule
